>>> src/mfe_pkg.sv
`default_nettype none
package mfe_pkg;

    // Default widths
    localparam int DEF_ANGLE_BITS = 16;
    localparam int DEF_FRAC_BITS  = 16;

    // Pipeline depths of the sine/cosine and matrix sections
    localparam int SC_LAT  = 8;
    localparam int ROT_LAT = 5;

    // Taylor coefficients of sin(pi/2*x), Q30
    localparam logic [30:0] Q30_ONE = 31'd1073741824;
    localparam logic [30:0] C_A1    = 31'd1686629713;
    localparam logic [30:0] C_A3    = 31'd693598670;
    localparam logic [30:0] C_A5    = 31'd85569305;
    localparam logic [30:0] C_A7    = 31'd5026994;
    localparam logic [30:0] C_A9    = 31'd172272;

    // Drop n bits, round to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int unsigned n);
        logic [63:0] m;
        m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
        m = (m + (64'd1 << (n - 1))) >> n;
        return v[63] ? -signed'(m) : signed'(m);
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/mfe_if.sv
`default_nettype none
// Input item channel
interface mfe_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [15:0] yaw_angle;
    logic        [15:0] pitch_angle;
    logic        [15:0] roll_angle;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;

    modport source (output valid, pos_x, pos_y, pos_z, yaw_angle, pitch_angle, roll_angle,
                    scale_x, scale_y, scale_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, yaw_angle, pitch_angle, roll_angle,
                    scale_x, scale_y, scale_z, output ready);
endinterface

// Result item channel
interface mfe_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] m_r0_c0;
    logic signed [31:0] m_r0_c1;
    logic signed [31:0] m_r0_c2;
    logic signed [31:0] m_r0_c3;
    logic signed [31:0] m_r1_c0;
    logic signed [31:0] m_r1_c1;
    logic signed [31:0] m_r1_c2;
    logic signed [31:0] m_r1_c3;
    logic signed [31:0] m_r2_c0;
    logic signed [31:0] m_r2_c1;
    logic signed [31:0] m_r2_c2;
    logic signed [31:0] m_r2_c3;

    modport source (output valid, m_r0_c0, m_r0_c1, m_r0_c2, m_r0_c3, m_r1_c0, m_r1_c1,
                    m_r1_c2, m_r1_c3, m_r2_c0, m_r2_c1, m_r2_c2, m_r2_c3, input ready);
    modport sink   (input valid, m_r0_c0, m_r0_c1, m_r0_c2, m_r0_c3, m_r1_c0, m_r1_c1,
                    m_r1_c2, m_r1_c3, m_r2_c0, m_r2_c1, m_r2_c2, m_r2_c3, output ready);
endinterface
`default_nettype wire

>>> src/model_matrix_from_euler_trs_unit.sv
`default_nettype none
// Model matrix builder, T * Ry(yaw) * Rx(pitch) * Rz(roll) * S, in signed fixed point.
// Fully pipelined: one item per cycle unless the output stalls. 8 stages of sine/cosine
// polynomial (angle fold, Horner multiplies, rounding), then 5 stages of matrix
// products, column scale and saturation. The whole pipeline advances when the output
// register is empty or being taken, so a result-side stall holds every stage.
module model_matrix_from_euler_trs_unit #(
    parameter int ANGLE_BITS = mfe_pkg::DEF_ANGLE_BITS,
    parameter int FRAC_BITS  = mfe_pkg::DEF_FRAC_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mfe_in_if.sink     i_in,
    mfe_out_if.source  o_out
);
    localparam int LAT = mfe_pkg::SC_LAT + mfe_pkg::ROT_LAT;
    localparam logic [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] n_vld;
    logic           en;

    logic [ANGLE_BITS-1:0] ay, ap, ar;
    logic signed [FRAC_BITS+1:0] sy, cy, sx, cx, sz, cz;
    logic signed [31:0] r_pos_d [mfe_pkg::SC_LAT][3];
    logic signed [31:0] r_scl_d [mfe_pkg::SC_LAT][3];
    logic signed [31:0] m [3][4];

    // Global advance
    assign en          = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = r_vld[LAT-1];

    assign n_vld = {r_vld[LAT-2:0], i_in.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    // Angles reduced to ANGLE_BITS
    assign ay = ANGLE_BITS'(i_in.yaw_angle);
    assign ap = ANGLE_BITS'(i_in.pitch_angle);
    assign ar = ANGLE_BITS'(i_in.roll_angle);

    mfe_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sy (
        .i_clk(i_clk), .i_en(en), .i_angle(ay), .o_val(sy));
    mfe_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cy (
        .i_clk(i_clk), .i_en(en), .i_angle(ay + QTR), .o_val(cy));
    mfe_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sx (
        .i_clk(i_clk), .i_en(en), .i_angle(ap), .o_val(sx));
    mfe_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cx (
        .i_clk(i_clk), .i_en(en), .i_angle(ap + QTR), .o_val(cx));
    mfe_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sz (
        .i_clk(i_clk), .i_en(en), .i_angle(ar), .o_val(sz));
    mfe_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cz (
        .i_clk(i_clk), .i_en(en), .i_angle(ar + QTR), .o_val(cz));

    // Position and scale delayed to meet the sines
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pos_d[0] <= '{i_in.pos_x, i_in.pos_y, i_in.pos_z};
            r_scl_d[0] <= '{i_in.scale_x, i_in.scale_y, i_in.scale_z};
            for (int k = 1; k < mfe_pkg::SC_LAT; k++) begin
                r_pos_d[k] <= r_pos_d[k-1];
                r_scl_d[k] <= r_scl_d[k-1];
            end
        end
    end

    mfe_rot #(.FRAC_BITS(FRAC_BITS)) u_rot (
        .i_clk(i_clk), .i_en(en),
        .i_sy(sy), .i_cy(cy), .i_sx(sx), .i_cx(cx), .i_sz(sz), .i_cz(cz),
        .i_pos(r_pos_d[mfe_pkg::SC_LAT-1]), .i_scale(r_scl_d[mfe_pkg::SC_LAT-1]),
        .o_m(m));

    assign o_out.m_r0_c0 = m[0][0];
    assign o_out.m_r0_c1 = m[0][1];
    assign o_out.m_r0_c2 = m[0][2];
    assign o_out.m_r0_c3 = m[0][3];
    assign o_out.m_r1_c0 = m[1][0];
    assign o_out.m_r1_c1 = m[1][1];
    assign o_out.m_r1_c2 = m[1][2];
    assign o_out.m_r1_c3 = m[1][3];
    assign o_out.m_r2_c0 = m[2][0];
    assign o_out.m_r2_c1 = m[2][1];
    assign o_out.m_r2_c2 = m[2][2];
    assign o_out.m_r2_c3 = m[2][3];

`ifndef SYNTHESIS
    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> r_vld == '0)
        else $error("pipeline not empty after reset");
    // A stall freezes every valid bit
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("valid bits moved during stall");
    // A taken result with a bubble behind it leaves the output empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !r_vld[LAT-2] |=> !o_out.valid)
        else $error("result repeated");
`endif
endmodule
`default_nettype wire

>>> src/mfe_sincos.sv
`default_nettype none
// Pipelined fixed-point sine: quadrant fold, Horner multiplies, then round and sign
module mfe_sincos #(
    parameter int ANGLE_BITS = mfe_pkg::DEF_ANGLE_BITS,
    parameter int FRAC_BITS  = mfe_pkg::DEF_FRAC_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [ANGLE_BITS-1:0]       i_angle,
    output logic signed [FRAC_BITS+1:0]      o_val
);
    localparam int RS = 30 - FRAC_BITS;
    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

    logic [30:0] r_xs  [0:5];
    logic [1:0]  r_qs  [0:6];
    logic [30:0] r_x2s [1:4];
    logic [30:0] r_p   [0:3];
    logic [31:0] r_pp;
    logic signed [FRAC_BITS+1:0] r_out;

    logic [30:0] n_x;
    logic [61:0] mul_x2, mul_p0, mul_p1, mul_p2, mul_p3, mul_pp;
    logic [31:0] rd;
    logic [FRAC_BITS+1:0] mag;

    // Quadrant fold of the angle fraction
    always_comb begin
        n_x = 31'(i_angle[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
        if (i_angle[ANGLE_BITS-2]) begin
            n_x = mfe_pkg::Q30_ONE - n_x;
        end
    end

    // Horner steps on nonnegative Q30 values
    always_comb begin
        mul_x2 = 62'(r_xs[0]) * 62'(r_xs[0]);
        mul_p0 = 62'(mfe_pkg::C_A9) * 62'(r_x2s[1]);
        mul_p1 = 62'(r_p[0]) * 62'(r_x2s[2]);
        mul_p2 = 62'(r_p[1]) * 62'(r_x2s[3]);
        mul_p3 = 62'(r_p[2]) * 62'(r_x2s[4]);
        mul_pp = 62'(r_p[3]) * 62'(r_xs[5]);
    end

    // Round to FRAC_BITS, clamp to one; the sign is negated in the second half turn
    always_comb begin
        rd = (r_pp + (32'd1 << (RS - 1))) >> RS;
        if (rd > ONE) begin
            rd = ONE;
        end
        mag = rd[FRAC_BITS+1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xs[0]  <= n_x;
            r_qs[0]  <= i_angle[ANGLE_BITS-1:ANGLE_BITS-2];
            for (int i = 1; i <= 5; i++) begin
                r_xs[i] <= r_xs[i-1];
            end
            for (int i = 1; i <= 6; i++) begin
                r_qs[i] <= r_qs[i-1];
            end
            r_x2s[1] <= mul_x2[60:30];
            for (int i = 2; i <= 4; i++) begin
                r_x2s[i] <= r_x2s[i-1];
            end
            r_p[0] <= mfe_pkg::C_A7 - mul_p0[60:30];
            r_p[1] <= mfe_pkg::C_A5 - mul_p1[60:30];
            r_p[2] <= mfe_pkg::C_A3 - mul_p2[60:30];
            r_p[3] <= mfe_pkg::C_A1 - mul_p3[60:30];
            r_pp   <= mul_pp[61:30];
            r_out  <= r_qs[6][1] ? -signed'(mag) : signed'(mag);
        end
    end

    assign o_val = r_out;
endmodule
`default_nettype wire

>>> src/mfe_rot.sv
`default_nettype none
// Rotation matrix from sines and cosines, then column scale and saturation
module mfe_rot #(
    parameter int FRAC_BITS = mfe_pkg::DEF_FRAC_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic signed [FRAC_BITS+1:0] i_sy,
    input  wire logic signed [FRAC_BITS+1:0] i_cy,
    input  wire logic signed [FRAC_BITS+1:0] i_sx,
    input  wire logic signed [FRAC_BITS+1:0] i_cx,
    input  wire logic signed [FRAC_BITS+1:0] i_sz,
    input  wire logic signed [FRAC_BITS+1:0] i_cz,
    input  wire logic signed [31:0]          i_pos   [3],
    input  wire logic signed [31:0]          i_scale [3],
    output logic signed [31:0]               o_m     [3][4]
);
    localparam int W  = FRAC_BITS + 2;
    localparam int RW = FRAC_BITS + 3;
    localparam int PW = 2 * W;

    // stage A
    logic signed [W-1:0] r_a_sy, r_a_cy, r_a_sz, r_a_cz, r_a_sysx, r_a_cysx;
    logic signed [W-1:0] r_a_r02, r_a_r10, r_a_r11, r_a_r12, r_a_r22;
    // stage B
    logic signed [PW-1:0] r_b_p [8];
    logic signed [W-1:0]  r_b_r02, r_b_r10, r_b_r11, r_b_r12, r_b_r22;
    // stage C
    logic signed [RW-1:0] r_c_r [3][3];
    // stage D
    logic signed [RW+31:0] r_d_p [3][3];
    // stage E
    logic signed [31:0] r_e_m [3][4];
    // carried payload
    logic signed [31:0] r_pos [4][3];
    logic signed [31:0] r_scl [3][3];

    logic signed [PW:0] sum [4];

    always_comb begin
        sum[0] = (PW+1)'(r_b_p[0]) + (PW+1)'(r_b_p[1]);
        sum[1] = (PW+1)'(r_b_p[2]) - (PW+1)'(r_b_p[3]);
        sum[2] = (PW+1)'(r_b_p[4]) - (PW+1)'(r_b_p[5]);
        sum[3] = (PW+1)'(r_b_p[6]) + (PW+1)'(r_b_p[7]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // A: single products, rounded
            r_a_sy   <= i_sy;
            r_a_cy   <= i_cy;
            r_a_sz   <= i_sz;
            r_a_cz   <= i_cz;
            r_a_sysx <= W'(mfe_pkg::rnd_shift(64'(i_sy * i_sx), FRAC_BITS));
            r_a_cysx <= W'(mfe_pkg::rnd_shift(64'(i_cy * i_sx), FRAC_BITS));
            r_a_r02  <= W'(mfe_pkg::rnd_shift(64'(i_sy * i_cx), FRAC_BITS));
            r_a_r10  <= W'(mfe_pkg::rnd_shift(64'(i_cx * i_sz), FRAC_BITS));
            r_a_r11  <= W'(mfe_pkg::rnd_shift(64'(i_cx * i_cz), FRAC_BITS));
            r_a_r12  <= -i_sx;
            r_a_r22  <= W'(mfe_pkg::rnd_shift(64'(i_cy * i_cx), FRAC_BITS));
            // B: terms of the two-term entries
            r_b_p[0] <= r_a_cy * r_a_cz;
            r_b_p[1] <= r_a_sysx * r_a_sz;
            r_b_p[2] <= r_a_sysx * r_a_cz;
            r_b_p[3] <= r_a_cy * r_a_sz;
            r_b_p[4] <= r_a_cysx * r_a_sz;
            r_b_p[5] <= r_a_sy * r_a_cz;
            r_b_p[6] <= r_a_sy * r_a_sz;
            r_b_p[7] <= r_a_cysx * r_a_cz;
            r_b_r02  <= r_a_r02;
            r_b_r10  <= r_a_r10;
            r_b_r11  <= r_a_r11;
            r_b_r12  <= r_a_r12;
            r_b_r22  <= r_a_r22;
            // C: exact sums, rounded once
            r_c_r[0][0] <= RW'(mfe_pkg::rnd_shift(64'(sum[0]), FRAC_BITS));
            r_c_r[0][1] <= RW'(mfe_pkg::rnd_shift(64'(sum[1]), FRAC_BITS));
            r_c_r[0][2] <= RW'(r_b_r02);
            r_c_r[1][0] <= RW'(r_b_r10);
            r_c_r[1][1] <= RW'(r_b_r11);
            r_c_r[1][2] <= RW'(r_b_r12);
            r_c_r[2][0] <= RW'(mfe_pkg::rnd_shift(64'(sum[2]), FRAC_BITS));
            r_c_r[2][1] <= RW'(mfe_pkg::rnd_shift(64'(sum[3]), FRAC_BITS));
            r_c_r[2][2] <= RW'(r_b_r22);
            // D: column scale
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_d_p[i][j] <= (RW+32)'(r_c_r[i][j]) * (RW+32)'(r_scl[2][j]);
                end
            end
            // E: round and saturate
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_e_m[i][j] <= mfe_pkg::sat32(
                        mfe_pkg::rnd_shift(64'(r_d_p[i][j]), FRAC_BITS));
                end
                r_e_m[i][3] <= r_pos[3][i];
            end
            // payload carried alongside
            r_pos[0] <= i_pos;
            r_scl[0] <= i_scale;
            for (int k = 1; k < 4; k++) begin
                r_pos[k] <= r_pos[k-1];
            end
            for (int k = 1; k < 3; k++) begin
                r_scl[k] <= r_scl[k-1];
            end
        end
    end

    assign o_m = r_e_m;
endmodule
`default_nettype wire
